### src/lcdseq_pkg.sv
// Shared types, codes and timing constants of the character LCD write sequencer.
// No dependencies; every other file imports this package.
`default_nettype none
package lcdseq_pkg;

  localparam int LINE_CHARS = 16;
  localparam int CUR_SPAN   = 2 * LINE_CHARS;
  localparam int POS_W      = $clog2(CUR_SPAN);
  localparam int COL_W      = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;

  localparam logic [15:0] WAIT_SHORT    = 16'd50;
  localparam logic [15:0] WAIT_BYTE_END = 16'd100;
  localparam logic [15:0] WAIT_CLEAR    = 16'd3200;
  localparam logic [15:0] WAIT_HOME     = 16'd1600;
  localparam logic [15:0] WAIT_POWER    = 16'd50000;
  localparam logic [15:0] WAIT_WAKE     = 16'd5050;
  localparam logic [15:0] WAIT_STEP     = 16'd150;

  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_HOME  = 8'h02;
  localparam logic [7:0] CMD_DDRAM = 8'h80;

  localparam logic [3:0] NIB_WAKE  = 4'h3;
  localparam logic [3:0] NIB_4BIT  = 4'h2;

  localparam logic [3:0] STEP_POWER      = 4'd0;
  localparam logic [3:0] STEP_WAKE       = 4'd1;
  localparam logic [3:0] STEP_WAKE2      = 4'd2;
  localparam logic [3:0] STEP_WAKE3      = 4'd3;
  localparam logic [3:0] STEP_BYTES      = 4'd5;
  localparam logic [3:0] STEP_BYTE_START = 4'd13;
  localparam logic [3:0] STEP_LAST       = 4'd14;

  typedef enum logic [1:0] {
    ACT_INIT   = 2'd0,
    ACT_CMD    = 2'd1,
    ACT_DATA   = 2'd2,
    ACT_CURSOR = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_FUNCTION_SET = 3'd0,
    REG_DISPLAY_OFF  = 3'd1,
    REG_ENTRY_MODE   = 3'd2,
    REG_DISPLAY_ON   = 3'd3,
    REG_FIRST_BASE   = 3'd4,
    REG_SECOND_BASE  = 3'd5
  } reg_index_t;

  typedef enum logic [2:0] {
    PAIR_FUNCTION_SET = 3'd0,
    PAIR_DISPLAY_OFF  = 3'd1,
    PAIR_CLEAR        = 3'd2,
    PAIR_ENTRY_MODE   = 3'd3
  } init_pair_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic        reg_select;
    logic [3:0]  bus_nibble;
    logic        strobe_res;
    logic [15:0] wait_us;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] function_set_code;
    logic [7:0] display_off_code;
    logic [7:0] entry_mode_code;
    logic [7:0] display_on_code;
    logic [6:0] first_line_base;
    logic [6:0] second_line_base;
  } cfg_regs_t;

  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] data;
  } job_t;

endpackage
`default_nettype wire

### src/lcdseq_front.sv
// Front stage: accepts items, classifies the action and maps cursor positions to commands.
// Depends on lcdseq_pkg.
`default_nettype none
module lcdseq_front
  import lcdseq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  input  wire cfg_regs_t cfg,
  output logic           job_valid,
  input  wire logic      job_ready,
  output job_t           job
);

  logic             valid_r;
  job_t             job_r;
  job_t             job_nxt;
  logic [POS_W-1:0] pos;
  logic [COL_W-1:0] col;
  logic [6:0]       base;
  logic [6:0]       addr;

  assign in_ready  = !valid_r || job_ready;
  assign job_valid = valid_r;
  assign job       = job_r;

  always_comb begin
    pos  = POS_W'(in_data.value % CUR_SPAN);
    col  = COL_W'(pos % LINE_CHARS);
    base = (32'(pos) < LINE_CHARS) ? cfg.first_line_base : cfg.second_line_base;
    addr = base + 7'(col);
    job_nxt.is_init = 1'b0;
    job_nxt.rs      = 1'b0;
    job_nxt.data    = in_data.value;
    case (action_t'(in_data.action))
      ACT_INIT: begin
        job_nxt.is_init = 1'b1;
      end
      ACT_CMD: begin
        job_nxt.rs = 1'b0;
      end
      ACT_DATA: begin
        job_nxt.rs = 1'b1;
      end
      default: begin
        job_nxt.data = CMD_DDRAM | {1'b0, addr};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      job_r <= job_nxt;
    end
  end

endmodule
`default_nettype wire

### src/lcdseq_fifo.sv
// Two-entry job queue between the front stage and the bus sequencer.
// Depends on lcdseq_pkg.
`default_nettype none
module lcdseq_fifo
  import lcdseq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  wire job_t wr_data,
  output logic      rd_valid,
  input  wire logic rd_pop,
  output job_t      rd_data
);

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_rd) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(do_wr) - 2'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

### src/lcdseq_back.sv
// Bus sequencer: steps through the events of the head job and registers each result item.
// Depends on lcdseq_pkg.
`default_nettype none
module lcdseq_back
  import lcdseq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      job_valid,
  input  wire job_t      job,
  output logic           job_pop,
  input  wire cfg_regs_t cfg,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic       started_r;
  logic [3:0] step_r;
  logic       out_valid_r;
  out_item_t  out_r;
  out_item_t  ev;
  logic [3:0] cur_step;
  logic [3:0] off;
  logic [7:0] byte_sel;
  logic       load;
  logic       at_last;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign load      = job_valid && (!out_valid_r || out_ready);
  assign cur_step  = started_r ? step_r : (job.is_init ? STEP_POWER : STEP_BYTE_START);
  assign at_last   = (cur_step == STEP_LAST);
  assign job_pop   = load && at_last;

  always_comb begin
    off = cur_step - STEP_BYTES;
    case (init_pair_t'(off[3:1]))
      PAIR_FUNCTION_SET: byte_sel = cfg.function_set_code;
      PAIR_DISPLAY_OFF:  byte_sel = cfg.display_off_code;
      PAIR_CLEAR:        byte_sel = CMD_CLEAR;
      PAIR_ENTRY_MODE:   byte_sel = cfg.entry_mode_code;
      default:           byte_sel = job.is_init ? cfg.display_on_code : job.data;
    endcase
    ev.reg_select = job.rs;
    ev.strobe_res = 1'b1;
    ev.last       = at_last;
    ev.bus_nibble = NIB_WAKE;
    ev.wait_us    = WAIT_STEP;
    if (cur_step < STEP_BYTES) begin
      case (cur_step)
        STEP_POWER: begin
          ev.bus_nibble = 4'h0;
          ev.strobe_res = 1'b0;
          ev.wait_us    = WAIT_POWER;
        end
        STEP_WAKE: begin
          ev.wait_us = WAIT_WAKE;
        end
        STEP_WAKE2, STEP_WAKE3: begin
          ev.wait_us = WAIT_STEP;
        end
        default: begin
          ev.bus_nibble = NIB_4BIT;
        end
      endcase
    end else if (!off[0]) begin
      ev.bus_nibble = byte_sel[7:4];
      ev.wait_us    = WAIT_SHORT;
    end else begin
      ev.bus_nibble = byte_sel[3:0];
      if (!job.rs && byte_sel == CMD_CLEAR) begin
        ev.wait_us = WAIT_CLEAR;
      end else if (!job.rs && byte_sel == CMD_HOME) begin
        ev.wait_us = WAIT_HOME;
      end else begin
        ev.wait_us = WAIT_BYTE_END;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      step_r      <= STEP_POWER;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        started_r   <= !at_last;
        step_r      <= cur_step + 4'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= ev;
    end
  end

endmodule
`default_nettype wire

### src/char_lcd_nibble_write_sequencer_core.sv
// Top level of the 4-bit character LCD write sequencer: configuration registers,
// front stage, job queue and bus sequencer. Depends on lcdseq_pkg and the lcdseq modules.
// Path: the first result item of an item is registered in the front stage, the job queue and the output register.
// Throughput: the bus sequencer emits one result item per cycle while out_ready holds and a job
// waits; init gives 15 items, every other action 2.
// Reset: synchronous active-low; queue and output are emptied, registers take reset codes.
`default_nettype none
module char_lcd_nibble_write_sequencer_core
  import lcdseq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  cfg_regs_t cfg_r;
  logic      fr_valid;
  logic      fr_ready;
  job_t      fr_job;
  logic      q_valid;
  logic      q_pop;
  job_t      q_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.function_set_code <= 8'h28;
      cfg_r.display_off_code  <= 8'h08;
      cfg_r.entry_mode_code   <= 8'h06;
      cfg_r.display_on_code   <= 8'h0C;
      cfg_r.first_line_base   <= 7'd0;
      cfg_r.second_line_base  <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_FUNCTION_SET: cfg_r.function_set_code <= cfg_data;
        REG_DISPLAY_OFF:  cfg_r.display_off_code  <= cfg_data;
        REG_ENTRY_MODE:   cfg_r.entry_mode_code   <= cfg_data;
        REG_DISPLAY_ON:   cfg_r.display_on_code   <= cfg_data;
        REG_FIRST_BASE:   cfg_r.first_line_base   <= cfg_data[6:0];
        REG_SECOND_BASE:  cfg_r.second_line_base  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  lcdseq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job       (fr_job)
  );

  lcdseq_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_data  (fr_job),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_data  (q_job)
  );

  lcdseq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job       (q_job),
    .job_pop   (q_pop),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
